[rtl/quaternion_trs_matrix_macros.svh]
// Assertion macros for the quaternion TRS matrix block.
// Included by the top level; relies on signals named clk and rst in the including module.
`ifndef QUATERNION_TRS_MATRIX_MACROS_SVH
`define QUATERNION_TRS_MATRIX_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QTM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QTM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/qtm_pkg.sv]
// Package for the quaternion TRS matrix block: widths, limits, stage types
// and the restoring division step. No dependencies.
package qtm_pkg;

  localparam int QW = 16;
  localparam int SW = 16;
  localparam int TW = 32;
  localparam int MW = 24;
  localparam int PRW = 32;
  localparam int NW = 33;
  localparam int NUMW = 34;
  localparam int XW = 36;
  localparam int PW = 48;
  localparam int LW = 24;
  localparam int QTW = 24;
  localparam int NENT = 9;
  localparam int NAX = 3;
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES = LW / BITS_PER_STAGE;

  localparam logic [MW-1:0] MAT_MAX = 24'h7F_FFFF;
  localparam logic [QTW-1:0] Q_LIMIT = 24'h80_0000;

  typedef logic [TW-1:0] trans_t;

  typedef struct packed {
    logic [NW-1:0] rem;
    logic [LW-1:0] low;
    logic [QTW-1:0] quot;
    logic neg;
  } div_t;

  function automatic div_t div_step(div_t din, logic [NW-1:0] den);
    div_t v;
    logic [NW:0] t;
    v = din;
    for (int i = 0; i < BITS_PER_STAGE; i++) begin
      t = {v.rem, v.low[LW-1]};
      v.low = {v.low[LW-2:0], 1'b0};
      if (t >= {1'b0, den}) begin
        v.rem = NW'(t - {1'b0, den});
        v.quot = {v.quot[QTW-2:0], 1'b1};
      end else begin
        v.rem = t[NW-1:0];
        v.quot = {v.quot[QTW-2:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

[rtl/quaternion_trs_matrix.sv]
// Start to done: registers a, b, c, the divider stages, then the output register.
// Throughput: one transform per cycle; busy is always low and the pipeline never stalls.
// Cost per beat: 10 small products, 9 33x16 products, then 9 restoring dividers at 2 bits/stage.
// Reset clears all valid bits; payload registers are not reset.
// Depends on qtm_pkg and quaternion_trs_matrix_macros.svh.
`include "quaternion_trs_matrix_macros.svh"

module quaternion_trs_matrix (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [qtm_pkg::QW-1:0]     quat_x,
  input  logic signed [qtm_pkg::QW-1:0]     quat_y,
  input  logic signed [qtm_pkg::QW-1:0]     quat_z,
  input  logic signed [qtm_pkg::QW-1:0]     quat_w,
  input  logic signed [qtm_pkg::SW-1:0]     scale_x,
  input  logic signed [qtm_pkg::SW-1:0]     scale_y,
  input  logic signed [qtm_pkg::SW-1:0]     scale_z,
  input  logic signed [qtm_pkg::TW-1:0]     trans_x,
  input  logic signed [qtm_pkg::TW-1:0]     trans_y,
  input  logic signed [qtm_pkg::TW-1:0]     trans_z,
  output logic                              done,
  output logic signed [qtm_pkg::MW-1:0]     row0_col0,
  output logic signed [qtm_pkg::MW-1:0]     row0_col1,
  output logic signed [qtm_pkg::MW-1:0]     row0_col2,
  output logic signed [qtm_pkg::TW-1:0]     row0_col3,
  output logic signed [qtm_pkg::MW-1:0]     row1_col0,
  output logic signed [qtm_pkg::MW-1:0]     row1_col1,
  output logic signed [qtm_pkg::MW-1:0]     row1_col2,
  output logic signed [qtm_pkg::TW-1:0]     row1_col3,
  output logic signed [qtm_pkg::MW-1:0]     row2_col0,
  output logic signed [qtm_pkg::MW-1:0]     row2_col1,
  output logic signed [qtm_pkg::MW-1:0]     row2_col2,
  output logic signed [qtm_pkg::TW-1:0]     row2_col3
);
  import qtm_pkg::*;

  logic a_valid;
  logic signed [PRW-1:0] a_xx, a_yy, a_zz, a_ww, a_xy, a_xz, a_yz, a_wx, a_wy, a_wz;
  logic signed [SW-1:0] a_sc [NAX];
  trans_t a_tr [NAX];

  logic b_valid;
  logic [NW-1:0] b_n;
  logic signed [NUMW-1:0] b_num [NENT];
  logic signed [SW-1:0] b_sc [NAX];
  trans_t b_tr [NAX];

  logic c_valid;
  logic [NW-1:0] c_n;
  logic [PW-1:0] c_prod [NENT];
  logic c_neg [NENT];
  trans_t c_tr [NAX];

  logic [DIV_STAGES-1:0] d_valid;
  div_t d_st [DIV_STAGES][NENT];
  logic [NW-1:0] d_n [DIV_STAGES];
  trans_t d_tr [DIV_STAGES][NAX];

  logic [MW-1:0] out_ent [NENT];
  trans_t out_tr [NAX];

  logic signed [XW-1:0] n_ext;
  logic signed [XW-1:0] num_ext [NENT];
  logic [NW-1:0] n_next;
  logic signed [NUMW-1:0] num_next [NENT];
  logic [PW-1:0] prod_next [NENT];
  logic neg_next [NENT];
  logic [MW-1:0] ent_next [NENT];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= '0;
      done <= 1'b0;
    end else begin
      a_valid <= start;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= {d_valid[DIV_STAGES-2:0], c_valid};
      done <= d_valid[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    a_xx <= quat_x * quat_x;
    a_yy <= quat_y * quat_y;
    a_zz <= quat_z * quat_z;
    a_ww <= quat_w * quat_w;
    a_xy <= quat_x * quat_y;
    a_xz <= quat_x * quat_z;
    a_yz <= quat_y * quat_z;
    a_wx <= quat_w * quat_x;
    a_wy <= quat_w * quat_y;
    a_wz <= quat_w * quat_z;
    a_sc[0] <= scale_x;
    a_sc[1] <= scale_y;
    a_sc[2] <= scale_z;
    a_tr[0] <= trans_x;
    a_tr[1] <= trans_y;
    a_tr[2] <= trans_z;
  end

  always_comb begin
    n_ext = XW'(a_xx) + XW'(a_yy) + XW'(a_zz) + XW'(a_ww);
    num_ext[0] = n_ext - 2 * (XW'(a_yy) + XW'(a_zz));
    num_ext[1] = 2 * (XW'(a_xy) - XW'(a_wz));
    num_ext[2] = 2 * (XW'(a_xz) + XW'(a_wy));
    num_ext[3] = 2 * (XW'(a_xy) + XW'(a_wz));
    num_ext[4] = n_ext - 2 * (XW'(a_xx) + XW'(a_zz));
    num_ext[5] = 2 * (XW'(a_yz) - XW'(a_wx));
    num_ext[6] = 2 * (XW'(a_xz) - XW'(a_wy));
    num_ext[7] = 2 * (XW'(a_yz) + XW'(a_wx));
    num_ext[8] = n_ext - 2 * (XW'(a_xx) + XW'(a_yy));
    if (n_ext == '0) begin
      n_next = NW'(1);
      for (int e = 0; e < NENT; e++) begin
        num_next[e] = (e % 4 == 0) ? NUMW'(1) : '0;
      end
    end else begin
      n_next = n_ext[NW-1:0];
      for (int e = 0; e < NENT; e++) begin
        num_next[e] = num_ext[e][NUMW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    b_n <= n_next;
    b_num <= num_next;
    b_sc <= a_sc;
    b_tr <= a_tr;
  end

  always_comb begin
    for (int e = 0; e < NENT; e++) begin
      logic [NUMW-1:0] mag_num;
      logic [SW-1:0] mag_sc;
      logic [PW:0] full;
      mag_num = b_num[e][NUMW-1] ? NUMW'(-b_num[e]) : NUMW'(b_num[e]);
      mag_sc = b_sc[e % NAX][SW-1] ? SW'(-b_sc[e % NAX]) : SW'(b_sc[e % NAX]);
      full = (PW+1)'(mag_num[NW-1:0]) * (PW+1)'(mag_sc);
      prod_next[e] = full[PW-1:0];
      neg_next[e] = b_num[e][NUMW-1] ^ b_sc[e % NAX][SW-1];
    end
  end

  always_ff @(posedge clk) begin
    c_n <= b_n;
    c_prod <= prod_next;
    c_neg <= neg_next;
    c_tr <= b_tr;
  end

  always_ff @(posedge clk) begin
    for (int e = 0; e < NENT; e++) begin
      d_st[0][e] <= div_step('{rem: NW'(c_prod[e][PW-1:PW-PRW]),
                               low: {c_prod[e][PW-PRW-1:0], 8'h00},
                               quot: '0, neg: c_neg[e]}, c_n);
    end
    d_n[0] <= c_n;
    d_tr[0] <= c_tr;
    for (int s = 1; s < DIV_STAGES; s++) begin
      for (int e = 0; e < NENT; e++) begin
        d_st[s][e] <= div_step(d_st[s-1][e], d_n[s-1]);
      end
      d_n[s] <= d_n[s-1];
      d_tr[s] <= d_tr[s-1];
    end
  end

  always_comb begin
    for (int e = 0; e < NENT; e++) begin
      logic [QTW-1:0] q;
      q = d_st[DIV_STAGES-1][e].quot +
          QTW'({d_st[DIV_STAGES-1][e].rem, 1'b0} >= {1'b0, d_n[DIV_STAGES-1]});
      if (d_st[DIV_STAGES-1][e].neg) begin
        ent_next[e] = MW'(-q);
      end else if (q == Q_LIMIT) begin
        ent_next[e] = MAT_MAX;
      end else begin
        ent_next[e] = MW'(q);
      end
    end
  end

  always_ff @(posedge clk) begin
    out_ent <= ent_next;
    out_tr <= d_tr[DIV_STAGES-1];
  end

  assign row0_col0 = out_ent[0];
  assign row0_col1 = out_ent[1];
  assign row0_col2 = out_ent[2];
  assign row0_col3 = out_tr[0];
  assign row1_col0 = out_ent[3];
  assign row1_col1 = out_ent[4];
  assign row1_col2 = out_ent[5];
  assign row1_col3 = out_tr[1];
  assign row2_col0 = out_ent[6];
  assign row2_col1 = out_ent[7];
  assign row2_col2 = out_ent[8];
  assign row2_col3 = out_tr[2];

  `QTM_ASSERT_NEXT(a_start_enters, start, a_valid, "accepted beat did not enter the pipeline")
  `QTM_ASSERT_NEXT(a_div_enters, c_valid, d_valid[0], "beat lost before the dividers")
  `QTM_ASSERT_NEXT(a_div_leaves, d_valid[DIV_STAGES-1], done, "beat lost after the dividers")
  `QTM_ASSERT_SAME(a_trans_kept, done, row0_col3 == $past(trans_x, 16), "translation x corrupted")

endmodule
